@@ design/plt_pkg.sv @@
// Shared types and constants for the palette lookup / interpolation block.
// No dependencies.
package plt_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CH_BITS   = 8;
    localparam int COLOR_W   = 32;
    localparam int SIDE_W    = 2 * COLOR_W;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_OUTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_INNER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOLID_OUTER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOLID_INNER    = 3'd4;

    localparam logic        CMD_WRITE = 1'b0;
    localparam logic        CMD_LOOKUP = 1'b1;
    localparam logic        XFER_NONE = 1'b0;
    localparam logic [31:0] SOLID_RESET = 32'h0000_00FF;

    // Control bits that travel with every item.
    typedef struct packed {
        logic valid;
        logic lookup;
        logic wr;
        logic use_solid;
    } t_ctl;

endpackage

@@ design/plt_if.sv @@
// Channel interfaces: palette item input, color output, configuration writes.
// Depends on plt_pkg.
interface plt_item_if #(parameter int FRAC_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [7:0]             entry_slot;
    logic [FRAC_BITS:0]     entry_position;
    logic [7:0]             entry_red;
    logic [7:0]             entry_green;
    logic [7:0]             entry_blue;
    logic [7:0]             entry_alpha;
    logic [FRAC_BITS+7:0]   lookup_index;
    logic                   fate;
    logic                   solid;
    modport source (output valid, cmd, entry_slot, entry_position, entry_red, entry_green,
                    entry_blue, entry_alpha, lookup_index, fate, solid, input ready);
    modport sink (input valid, cmd, entry_slot, entry_position, entry_red, entry_green,
                  entry_blue, entry_alpha, lookup_index, fate, solid, output ready);
endinterface

interface plt_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface plt_cfg_if;
    import plt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/plt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/plt_search_level.sv @@
// One level of the pipelined binary search: address cycle, then compare cycle.
// Holds its own copy of the entry positions. Depends on plt_pkg, plt_ram.
module plt_search_level import plt_pkg::*; #(
    parameter int MAX_ENTRIES = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  t_ctl                           i_ctl,
    input  logic [7:0]                     i_slot,
    input  logic [FRAC_BITS:0]             i_pos,
    input  logic [SIDE_W-1:0]              i_side,
    input  logic [FRAC_BITS:0]             i_key,
    input  logic [$clog2(MAX_ENTRIES):0]   i_left,
    input  logic [$clog2(MAX_ENTRIES):0]   i_rp,
    input  logic                           i_done,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_res,
    output t_ctl                           o_ctl,
    output logic [7:0]                     o_slot,
    output logic [FRAC_BITS:0]             o_pos,
    output logic [SIDE_W-1:0]              o_side,
    output logic [FRAC_BITS:0]             o_key,
    output logic [$clog2(MAX_ENTRIES):0]   o_left,
    output logic [$clog2(MAX_ENTRIES):0]   o_rp,
    output logic                           o_done,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_res
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;
    localparam int PW = FRAC_BITS + 1;

    logic [CW:0]   sum;
    logic [AW-1:0] mid;
    logic [31:0]   slot_ext;
    logic [PW-1:0] rdata;
    logic          a_done;
    logic [AW-1:0] a_res;

    t_ctl          r_a_ctl;
    logic [7:0]    r_a_slot;
    logic [PW-1:0] r_a_pos;
    logic [SIDE_W-1:0] r_a_side;
    logic [PW-1:0] r_a_key;
    logic [CW-1:0] r_a_left, r_a_rp;
    logic          r_a_done;
    logic [AW-1:0] r_a_res, r_a_mid;

    t_ctl          r_b_ctl;
    logic [7:0]    r_b_slot;
    logic [PW-1:0] r_b_pos;
    logic [SIDE_W-1:0] r_b_side;
    logic [PW-1:0] r_b_key;
    logic [CW-1:0] r_b_left, r_b_rp;
    logic          r_b_done;
    logic [AW-1:0] r_b_res;

    assign sum      = {1'b0, i_left} + {1'b0, i_rp} - (CW+1)'(1);
    assign mid      = sum[AW:1];
    assign slot_ext = 32'(i_slot);

    // Range empty: the search ends on the entry just below left.
    always_comb begin
        a_done = i_done;
        a_res  = i_res;
        if (!i_done && i_left >= i_rp) begin
            a_done = 1'b1;
            a_res  = (i_left == '0) ? '0 : AW'(i_left - CW'(1));
        end
    end

    plt_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES)) u_pos (
        .i_clk   (i_clk),
        .i_we    (i_en && i_ctl.valid && i_ctl.wr),
        .i_waddr (slot_ext[AW-1:0]),
        .i_wdata (i_pos),
        .i_re    (i_en),
        .i_raddr (mid),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_slot <= i_slot;
            r_a_pos  <= i_pos;
            r_a_side <= i_side;
            r_a_key  <= i_key;
            r_a_left <= i_left;
            r_a_rp   <= i_rp;
            r_a_done <= a_done;
            r_a_res  <= a_res;
            r_a_mid  <= mid;

            r_b_slot <= r_a_slot;
            r_b_pos  <= r_a_pos;
            r_b_side <= r_a_side;
            r_b_key  <= r_a_key;
            r_b_left <= r_a_left;
            r_b_rp   <= r_a_rp;
            r_b_done <= r_a_done;
            r_b_res  <= r_a_res;
            if (!r_a_done) begin
                if (rdata < r_a_key) begin
                    r_b_left <= CW'(r_a_mid) + CW'(1);
                end else if (rdata == r_a_key) begin
                    r_b_done <= 1'b1;
                    r_b_res  <= r_a_mid;
                end else begin
                    r_b_rp <= CW'(r_a_mid);
                end
            end
        end
    end

    assign o_ctl  = r_b_ctl;
    assign o_slot = r_b_slot;
    assign o_pos  = r_b_pos;
    assign o_side = r_b_side;
    assign o_key  = r_b_key;
    assign o_left = r_b_left;
    assign o_rp   = r_b_rp;
    assign o_done = r_b_done;
    assign o_res  = r_b_res;
endmodule

@@ design/plt_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, four channels.
// Quotients fit CH_BITS bits. Depends on plt_pkg.
module plt_divider import plt_pkg::*; #(
    parameter int DW     = 17,
    parameter int PASS_W = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [CH_BITS+DW-1:0]  i_num [4],
    input  logic [DW-1:0]          i_den,
    input  logic [PASS_W-1:0]      i_pass,
    output logic                   o_valid,
    output logic [CH_BITS-1:0]     o_quo [4],
    output logic [PASS_W-1:0]      o_pass
);
    localparam int NW = CH_BITS + DW;

    logic              r_valid [CH_BITS+1];
    logic [NW-1:0]     r_rem   [CH_BITS+1][4];
    logic [CH_BITS-1:0] r_quo  [CH_BITS+1][4];
    logic [DW-1:0]     r_den   [CH_BITS+1];
    logic [PASS_W-1:0] r_pass  [CH_BITS+1];

    always_comb begin
        r_valid[0] = i_valid;
        r_den[0]   = i_den;
        r_pass[0]  = i_pass;
        for (int c = 0; c < 4; c++) begin
            r_rem[0][c] = i_num[c];
            r_quo[0][c] = '0;
        end
    end

    for (genvar s = 0; s < CH_BITS; s++) begin : g_stage
        localparam int K = CH_BITS - 1 - s;
        logic [NW-1:0] dsh;
        assign dsh = NW'(r_den[s]) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1]  <= r_den[s];
                r_pass[s+1] <= r_pass[s];
                for (int c = 0; c < 4; c++) begin
                    if (r_rem[s][c] >= dsh) begin
                        r_rem[s+1][c]    <= r_rem[s][c] - dsh;
                        r_quo[s+1][c]    <= r_quo[s][c] | CH_BITS'(1 << K);
                    end else begin
                        r_rem[s+1][c]    <= r_rem[s][c];
                        r_quo[s+1][c]    <= r_quo[s][c];
                    end
                end
            end
        end
    end

    assign o_valid = r_valid[CH_BITS];
    assign o_pass  = r_pass[CH_BITS];
    assign o_quo   = r_quo[CH_BITS];
endmodule

@@ design/palette_lookup_interpolate.sv @@
// Top level: palette lookup with linear blend between neighboring entries.
// Depends on plt_pkg, plt_if, plt_ram, plt_search_level, plt_divider.
//
// Channels: i_item takes palette writes (cmd 0) and color lookups (cmd 1);
// o_color returns one RGBA item per lookup and none per write; i_cfg writes
// the configuration registers (always ready); the user must write them only
// while the block is idle, and the block itself does not enforce this.
// Throughput: one item per cycle while o_color is not stalled. A lookup runs
// in order through the binary-search levels (each a position RAM read and a
// compare), the fetch of both neighbors and the products, the bit-per-stage
// divider and the output register before its result reaches o_color.
// A palette write passes down the same pipe and updates each level's copy
// of the positions as it goes, so lookups see writes in item order.
// Reset clears all valid bits and loads the register defaults; palette
// contents are undefined until written. When the receiver stalls, the whole
// pipe holds and i_item.ready drops; nothing is lost or repeated.
module palette_lookup_interpolate import plt_pkg::*; #(
    parameter int MAX_ENTRIES = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    plt_item_if.sink      i_item,
    plt_color_if.source   o_color,
    plt_cfg_if.sink       i_cfg
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;
    localparam int PW = FRAC_BITS + 1;
    localparam int NW = CH_BITS + PW;
    localparam int LV = $clog2(MAX_ENTRIES + 1);
    localparam int PASS_W = $bits(t_ctl) + 1 + 2 * COLOR_W;
    localparam logic [PW-1:0] ONE_FIX = PW'(1) << FRAC_BITS;

    logic [8:0]  r_color_count;
    logic        r_xfer_outer, r_xfer_inner;
    logic [31:0] r_solid_outer, r_solid_inner;

    logic        en;
    logic [CW-1:0] count_eff;
    logic [31:0] slot_ext;

    // Configuration port
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_count <= 9'd1;
            r_xfer_outer  <= 1'b1;
            r_xfer_inner  <= 1'b1;
            r_solid_outer <= SOLID_RESET;
            r_solid_inner <= SOLID_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COLOR_COUNT:    r_color_count <= i_cfg.data[8:0];
                REG_TRANSFER_OUTER: r_xfer_outer  <= i_cfg.data[0];
                REG_TRANSFER_INNER: r_xfer_inner  <= i_cfg.data[0];
                REG_SOLID_OUTER:    r_solid_outer <= i_cfg.data;
                REG_SOLID_INNER:    r_solid_inner <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_color_count == '0) begin
            count_eff = CW'(1);
        end else if (32'(r_color_count) > 32'(MAX_ENTRIES)) begin
            count_eff = CW'(MAX_ENTRIES);
        end else begin
            count_eff = CW'(r_color_count);
        end
    end

    logic r_out_valid;
    assign en           = !r_out_valid || o_color.ready;
    assign i_item.ready = en;

    // Entry: decode the item and wrap the index
    t_ctl          in_ctl;
    logic [PW-1:0] in_key;
    logic [FRAC_BITS+7:0] idx;
    logic          inner, xfer;

    assign idx      = i_item.lookup_index;
    assign inner    = i_item.fate;
    assign xfer     = inner ? r_xfer_inner : r_xfer_outer;
    assign slot_ext = 32'(i_item.entry_slot);
    assign in_key   = (idx == (FRAC_BITS+8)'(ONE_FIX)) ? ONE_FIX : {1'b0, idx[FRAC_BITS-1:0]};

    always_comb begin
        in_ctl.valid     = i_item.valid;
        in_ctl.lookup    = (i_item.cmd == CMD_LOOKUP);
        in_ctl.wr        = (i_item.cmd == CMD_WRITE) && (slot_ext < 32'(MAX_ENTRIES));
        in_ctl.use_solid = i_item.solid || (xfer == XFER_NONE);
    end

    // Search levels
    t_ctl              lv_ctl  [LV+1];
    logic [7:0]        lv_slot [LV+1];
    logic [PW-1:0]     lv_pos  [LV+1];
    logic [SIDE_W-1:0] lv_side [LV+1];
    logic [PW-1:0]     lv_key  [LV+1];
    logic [CW-1:0]     lv_left [LV+1];
    logic [CW-1:0]     lv_rp   [LV+1];
    logic              lv_done [LV+1];
    logic [AW-1:0]     lv_res  [LV+1];

    assign lv_ctl[0]  = in_ctl;
    assign lv_slot[0] = i_item.entry_slot;
    assign lv_pos[0]  = i_item.entry_position;
    assign lv_side[0] = {i_item.entry_red, i_item.entry_green, i_item.entry_blue,
                         i_item.entry_alpha, inner ? r_solid_inner : r_solid_outer};
    assign lv_key[0]  = in_key;
    assign lv_left[0] = '0;
    assign lv_rp[0]   = count_eff;
    assign lv_done[0] = 1'b0;
    assign lv_res[0]  = '0;

    for (genvar l = 0; l < LV; l++) begin : g_level
        plt_search_level #(.MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_level (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (lv_ctl[l]),
            .i_slot (lv_slot[l]),
            .i_pos  (lv_pos[l]),
            .i_side (lv_side[l]),
            .i_key  (lv_key[l]),
            .i_left (lv_left[l]),
            .i_rp   (lv_rp[l]),
            .i_done (lv_done[l]),
            .i_res  (lv_res[l]),
            .o_ctl  (lv_ctl[l+1]),
            .o_slot (lv_slot[l+1]),
            .o_pos  (lv_pos[l+1]),
            .o_side (lv_side[l+1]),
            .o_key  (lv_key[l+1]),
            .o_left (lv_left[l+1]),
            .o_rp   (lv_rp[l+1]),
            .o_done (lv_done[l+1]),
            .o_res  (lv_res[l+1])
        );
    end

    // Fetch: read the found entry and its right neighbor
    t_ctl          s_ctl;
    logic [CW-1:0] s_left;
    logic [AW-1:0] sel, sel_next, waddr;
    logic [31:0]   wslot;
    logic          f_we;

    assign s_ctl    = lv_ctl[LV];
    assign s_left   = lv_left[LV];
    assign sel      = lv_done[LV] ? lv_res[LV] :
                      ((s_left == '0) ? '0 : AW'(s_left - CW'(1)));
    assign sel_next = sel + AW'(1);
    assign wslot    = 32'(lv_slot[LV]);
    assign waddr    = wslot[AW-1:0];
    assign f_we     = en && s_ctl.valid && s_ctl.wr;

    logic [PW-1:0]      pi, pj;
    logic [COLOR_W-1:0] cl, cr;

    plt_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES)) u_pos_lo (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(waddr), .i_wdata(lv_pos[LV]),
        .i_re(en), .i_raddr(sel), .o_rdata(pi));
    plt_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES)) u_pos_hi (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(waddr), .i_wdata(lv_pos[LV]),
        .i_re(en), .i_raddr(sel_next), .o_rdata(pj));
    plt_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_ENTRIES)) u_col_lo (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(waddr),
        .i_wdata(lv_side[LV][SIDE_W-1:COLOR_W]),
        .i_re(en), .i_raddr(sel), .o_rdata(cl));
    plt_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_ENTRIES)) u_col_hi (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(waddr),
        .i_wdata(lv_side[LV][SIDE_W-1:COLOR_W]),
        .i_re(en), .i_raddr(sel_next), .o_rdata(cr));

    t_ctl               r_f1_ctl;
    logic [PW-1:0]      r_f1_key;
    logic               r_f1_last;
    logic [COLOR_W-1:0] r_f1_solid;

    // Offsets and gap
    logic          noblend;
    logic [PW-1:0] gap, off, off_sat;
    assign noblend = (r_f1_key <= pi) || r_f1_last || (pj <= pi);
    assign gap     = pj - pi;
    assign off     = r_f1_key - pi;
    assign off_sat = (off > gap) ? gap : off;

    t_ctl               r_f2_ctl;
    logic [COLOR_W-1:0] r_f2_solid, r_f2_cl, r_f2_cr;
    logic               r_f2_noblend;
    logic [PW-1:0]      r_f2_d, r_f2_o;

    t_ctl               r_f3_ctl;
    logic [COLOR_W-1:0] r_f3_solid, r_f3_cl;
    logic               r_f3_noblend;
    logic [PW-1:0]      r_f3_d;
    logic [NW-1:0]      r_f3_num [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_ctl <= '0;
            r_f2_ctl <= '0;
            r_f3_ctl <= '0;
        end else if (en) begin
            r_f1_ctl <= s_ctl;
            r_f2_ctl <= r_f1_ctl;
            r_f3_ctl <= r_f2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_key     <= lv_key[LV];
            r_f1_last    <= (CW'(sel) == count_eff - CW'(1));
            r_f1_solid   <= lv_side[LV][COLOR_W-1:0];

            r_f2_solid   <= r_f1_solid;
            r_f2_cl      <= cl;
            r_f2_cr      <= cr;
            r_f2_noblend <= noblend;
            r_f2_d       <= gap;
            r_f2_o       <= off_sat;

            r_f3_solid   <= r_f2_solid;
            r_f3_cl      <= r_f2_cl;
            r_f3_noblend <= r_f2_noblend;
            r_f3_d       <= r_f2_d;
            for (int c = 0; c < 4; c++) begin
                r_f3_num[c] <= NW'(r_f2_cl[8*c +: 8]) * NW'(r_f2_d - r_f2_o)
                             + NW'(r_f2_cr[8*c +: 8]) * NW'(r_f2_o);
            end
        end
    end

    // Divide each blended channel by the gap
    logic               dv_valid;
    logic [CH_BITS-1:0] dv_quo [4];
    logic [PASS_W-1:0]  dv_pass;
    t_ctl               dv_ctl;
    logic               dv_noblend;
    logic [COLOR_W-1:0] dv_cl, dv_solid, blend, result;

    plt_divider #(.DW(PW), .PASS_W(PASS_W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_f3_ctl.valid),
        .i_num  (r_f3_num),
        .i_den  (r_f3_d),
        .i_pass ({r_f3_ctl, r_f3_noblend, r_f3_cl, r_f3_solid}),
        .o_valid(dv_valid),
        .o_quo  (dv_quo),
        .o_pass (dv_pass)
    );

    assign {dv_ctl, dv_noblend, dv_cl, dv_solid} = dv_pass;
    assign blend  = {dv_quo[3], dv_quo[2], dv_quo[1], dv_quo[0]};
    assign result = dv_ctl.use_solid ? dv_solid : (dv_noblend ? dv_cl : blend);

    // Output register
    logic [COLOR_W-1:0] r_out_color;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid && dv_ctl.lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_color <= result;
        end
    end

    assign o_color.valid     = r_out_valid;
    assign o_color.out_red   = r_out_color[31:24];
    assign o_color.out_green = r_out_color[23:16];
    assign o_color.out_blue  = r_out_color[15:8];
    assign o_color.out_alpha = r_out_color[7:0];

    // The found entry always lies inside the palette in use.
    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_ctl.valid && s_ctl.lookup) |-> (CW'(sel) < count_eff))
        else $error("search result beyond color count");

    // A blend never runs with a zero gap or an offset past the gap.
    a_blend_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_f2_ctl.valid && !r_f2_noblend) |-> (r_f2_d != '0 && r_f2_o <= r_f2_d))
        else $error("blend with bad gap");

    // A stalled result holds its color.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_color.ready) |=> (r_out_valid && $stable(r_out_color)))
        else $error("result changed under stall");

endmodule

@@ verif/plt_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for palette_lookup_interpolate: watches the item, color and config
// channels, keeps its own palette and registers, and checks each color item.
// Depends on plt_pkg and plt_if.
module plt_checker import plt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    plt_item_if  itm,
    plt_color_if col,
    plt_cfg_if   cfg,
    output int   o_fail_count,
    output int   o_pending
);

    logic [16:0] pal_pos [256];
    logic [31:0] pal_rgba [256];
    logic [8:0]  color_count;
    logic        xfer_outer;
    logic        xfer_inner;
    logic [31:0] solid_outer;
    logic [31:0] solid_inner;
    logic [31:0] rgba_expected [$];

    function automatic logic [31:0] palette_rgba(logic [23:0] raw);
        logic [16:0] key;
        logic [16:0] pi;
        logic [16:0] pj;
        int unsigned gap;
        int unsigned ofs;
        int unsigned a;
        int unsigned b;
        int n;
        int lo;
        int hi;
        int mid;
        int hit;
        logic [31:0] res;
        key = (raw == 24'h01_0000) ? 17'h1_0000 : {1'b0, raw[15:0]};
        n = color_count;
        if (n < 1) n = 1;
        if (n > 256) n = 256;
        lo = 0;
        hi = n - 1;
        hit = -1;
        while (hit < 0) begin
            if (lo > hi) begin
                hit = (lo - 1 < 0) ? 0 : lo - 1;
            end else begin
                mid = (lo + hi) / 2;
                if (pal_pos[mid] < key) lo = mid + 1;
                else if (pal_pos[mid] == key) hit = mid;
                else hi = mid - 1;
            end
        end
        pi = pal_pos[hit];
        if (key <= pi || hit == n - 1) return pal_rgba[hit];
        pj = pal_pos[hit + 1];
        if (pj <= pi) return pal_rgba[hit];
        gap = pj - pi;
        ofs = key - pi;
        if (ofs > gap) ofs = gap;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            a = (pal_rgba[hit] >> (8 * k)) & 8'hFF;
            b = (pal_rgba[hit + 1] >> (8 * k)) & 8'hFF;
            res[8*k +: 8] = (a * (gap - ofs) + b * ofs) / gap;
        end
        return res;
    endfunction

    assign o_pending = rgba_expected.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        logic [31:0] got;
        if (!i_rst_n) begin
            color_count <= 9'd1;
            xfer_outer  <= 1'b1;
            xfer_inner  <= 1'b1;
            solid_outer <= SOLID_RESET;
            solid_inner <= SOLID_RESET;
            o_fail_count <= 0;
            rgba_expected.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_COLOR_COUNT:    color_count <= cfg.data[8:0];
                    REG_TRANSFER_OUTER: xfer_outer  <= cfg.data[0];
                    REG_TRANSFER_INNER: xfer_inner  <= cfg.data[0];
                    REG_SOLID_OUTER:    solid_outer <= cfg.data;
                    REG_SOLID_INNER:    solid_inner <= cfg.data;
                    default: ;
                endcase
            end
            if (itm.valid && itm.ready) begin
                if (itm.cmd == CMD_WRITE) begin
                    pal_pos[itm.entry_slot]  = itm.entry_position;
                    pal_rgba[itm.entry_slot] = {itm.entry_red, itm.entry_green,
                                                itm.entry_blue, itm.entry_alpha};
                end else if (itm.fate) begin
                    rgba_expected.push_back((itm.solid || xfer_inner == XFER_NONE) ?
                                            solid_inner : palette_rgba(itm.lookup_index));
                end else begin
                    rgba_expected.push_back((itm.solid || xfer_outer == XFER_NONE) ?
                                            solid_outer : palette_rgba(itm.lookup_index));
                end
            end
            if (col.valid && col.ready) begin
                got = {col.out_red, col.out_green, col.out_blue, col.out_alpha};
                if (rgba_expected.size() == 0) begin
                    $display("%0t: unexpected color item %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = rgba_expected.pop_front();
                    if (got !== want) begin
                        $display("%0t: color mismatch expected r%h g%h b%h a%h got r%h g%h b%h a%h",
                                 $time, want[31:24], want[23:16], want[15:8], want[7:0],
                                 got[31:24], got[23:16], got[15:8], got[7:0]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/tb_palette_lookup_interpolate.sv @@
`timescale 1ns / 1ps
// Testbench top for palette_lookup_interpolate: clock, reset, stimulus, verdict.
// Depends on plt_pkg, plt_if and plt_checker.
module tb_palette_lookup_interpolate;
    import plt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   n_lookups;
    int   n_writes;
    bit   calm;
    bit   hold_req;

    plt_item_if  itm ();
    plt_color_if col ();
    plt_cfg_if   cfg ();

    palette_lookup_interpolate u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (itm),
        .o_color(col),
        .i_cfg  (cfg)
    );

    plt_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .itm         (itm),
        .col         (col),
        .cfg         (cfg),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, plus one long hold on request.
    initial begin
        col.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                col.ready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end
            col.ready = calm || ($urandom_range(0, 99) >= 6);
        end
    end

    // Watchdog: stop if nothing moves for too long.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((itm.valid && itm.ready) || (col.valid && col.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 3000) begin
                $display("%0t: timeout with %0d color items outstanding", $time, pending);
                $display("FAIL palette_lookup_interpolate");
                $finish;
            end
        end
    end

    task automatic put_item(logic cmd, logic [7:0] slot, logic [16:0] pos,
                            logic [31:0] rgba, logic [23:0] idx, logic fate,
                            logic solid);
        if (!calm && $urandom_range(0, 99) < 6) begin
            itm.valid = 1'b0;
            @(negedge i_clk);
        end
        itm.cmd            = cmd;
        itm.entry_slot     = slot;
        itm.entry_position = pos;
        {itm.entry_red, itm.entry_green, itm.entry_blue, itm.entry_alpha} = rgba;
        itm.lookup_index   = idx;
        itm.fate           = fate;
        itm.solid          = solid;
        itm.valid          = 1'b1;
        do @(posedge i_clk); while (!itm.ready);
        if (cmd == CMD_WRITE) n_writes++;
        else n_lookups++;
        @(negedge i_clk);
    endtask

    task automatic write_entry(int slot, logic [16:0] pos);
        put_item(CMD_WRITE, slot[7:0], pos, $urandom, 24'($urandom), 1'($urandom),
                 1'($urandom));
    endtask

    task automatic lookup(logic [23:0] idx, logic fate, logic solid);
        put_item(CMD_LOOKUP, 8'($urandom), 17'($urandom), $urandom, idx, fate, solid);
    endtask

    // Drain: wait for every color item, then for the pipe to empty of writes.
    task automatic drain();
        itm.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        drain();
        cfg.index = idx;
        cfg.data  = data;
        cfg.valid = 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    // Load slots 0..n-1 with ascending positions from 0 to exactly 1.0.
    task automatic fill_ascending(int n);
        for (int s = 0; s < n; s++)
            write_entry(s, (n == 1) ? 17'h0 : 17'((s * 65536) / (n - 1)));
    endtask

    task automatic random_item();
        int pick;
        logic [16:0] pos;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            pos = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
            write_entry($urandom_range(0, 255), pos);
        end else if (pick < 70) begin
            lookup(24'($urandom_range(0, 65536)), 1'($urandom), $urandom_range(0, 9) == 0);
        end else if (pick < 80) begin
            lookup(24'(24'h01_0000 * $urandom_range(0, 255)), 1'($urandom), 1'b0);
        end else begin
            lookup(24'($urandom), 1'($urandom), $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        int counts [8];
        i_rst_n   = 1'b0;
        itm.valid = 1'b0;
        itm.cmd = CMD_WRITE;
        itm.entry_slot = '0;
        itm.entry_position = '0;
        {itm.entry_red, itm.entry_green, itm.entry_blue, itm.entry_alpha} = '0;
        itm.lookup_index = '0;
        itm.fate = 1'b0;
        itm.solid = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_COLOR_COUNT;
        cfg.data  = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        n_lookups = 0;
        n_writes = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Write the whole palette once so no lookup ever reads a fresh slot.
        fill_ascending(256);

        // Directed: reset registers, then wrap, exact hits and solids.
        lookup(24'h00_0000, 1'b0, 1'b0);
        lookup(24'h00_8000, 1'b1, 1'b0);
        lookup(24'h00_8000, 1'b0, 1'b1);
        lookup(24'h00_8000, 1'b1, 1'b1);
        cfg_write(REG_COLOR_COUNT, 32'd256);
        cfg_write(REG_SOLID_OUTER, 32'h0000_0000);
        cfg_write(REG_SOLID_INNER, 32'hFFFF_FFFF);
        lookup(24'h01_0000, 1'b0, 1'b0);
        lookup(24'h02_0000, 1'b1, 1'b0);
        lookup(24'hFF_FFFF, 1'b0, 1'b0);
        lookup(24'h00_FFFF, 1'b1, 1'b0);
        lookup(24'h00_0101, 1'b0, 1'b0);
        lookup(24'h00_0080, 1'b1, 1'b0);
        lookup(24'h05_4321, 1'b0, 1'b1);
        lookup(24'h05_4321, 1'b1, 1'b1);
        // Equal and out-of-order neighbors.
        write_entry(10, 17'h0_0A00);
        write_entry(11, 17'h0_0A00);
        write_entry(20, 17'h0_0100);
        lookup(24'h00_0A80, 1'b0, 1'b0);
        lookup(24'h00_1380, 1'b1, 1'b0);
        lookup(24'h00_1400, 1'b0, 1'b0);
        cfg_write(REG_TRANSFER_OUTER, {31'd0, XFER_NONE});
        cfg_write(REG_TRANSFER_INNER, {31'd0, XFER_NONE});
        lookup(24'h00_4000, 1'b0, 1'b0);
        lookup(24'h00_4000, 1'b1, 1'b0);
        cfg_write(REG_COLOR_COUNT, 32'd0);
        cfg_write(REG_TRANSFER_OUTER, 32'd1);
        cfg_write(REG_TRANSFER_INNER, 32'd1);
        lookup(24'h00_4000, 1'b0, 1'b0);
        cfg_write(REG_COLOR_COUNT, 32'd511);
        lookup(24'h00_C000, 1'b1, 1'b0);

        // Random phases, each with its own settings.
        counts = '{1, 256, 2, 17, 256, 5, 40, 3};
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(REG_COLOR_COUNT, counts[ph]);
            cfg_write(REG_TRANSFER_OUTER, (ph == 6) ? 32'd0 : 32'($urandom_range(0, 3) != 0));
            cfg_write(REG_TRANSFER_INNER, (ph == 7) ? 32'd0 : 32'($urandom_range(0, 3) != 0));
            cfg_write(REG_SOLID_OUTER, $urandom);
            cfg_write(REG_SOLID_INNER, $urandom);
            fill_ascending(counts[ph] > 64 ? 256 : counts[ph] + 1);
            calm = (ph == 3);
            for (int k = 0; k < 125; k++) begin
                if (ph == 4 && k == 20) hold_req = 1'b1;
                random_item();
            end
            calm = 1'b0;
        end
        drain();

        $display("Covered %0d lookups and %0d palette writes over 8 random phases,",
                 n_lookups, n_writes);
        $display("with wrap, exact hits, solids, out-of-order entries and counts 0..511.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS palette_lookup_interpolate");
        end else begin
            $display("FAIL palette_lookup_interpolate");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/plt_pkg.sv
design/plt_if.sv
design/plt_ram.sv
design/plt_search_level.sv
design/plt_divider.sv
design/palette_lookup_interpolate.sv
verif/plt_checker.sv
verif/tb_palette_lookup_interpolate.sv
